FILE: rtl/core/tsdp_pkg.sv
package tsdp_pkg;

  localparam int DescriptorsDefault = 16;
  localparam int ListCount          = 7;

  // Free-slot mask of a descriptor; the value doubles as its list number.
  typedef logic [2:0] class_t;

  localparam class_t SLOT_LOCAL   = 3'b001;
  localparam class_t SLOT_REMOTE  = 3'b010;
  localparam class_t SLOT_IRQ     = 3'b100;
  localparam class_t CLASS_UNUSED = 3'b111;

  typedef enum logic [2:0] {
    FUNC_GET_LOCAL   = 3'd0,
    FUNC_GET_REMOTE  = 3'd1,
    FUNC_GET_IRQ     = 3'd2,
    FUNC_FREE_LOCAL  = 3'd3,
    FUNC_FREE_REMOTE = 3'd4,
    FUNC_FREE_IRQ    = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EXHAUSTED   = 2'd1,
    ST_NOT_HELD    = 2'd2,
    ST_NOT_IN_USE  = 2'd3
  } status_e;

  // Register index, taken from paddr[2].
  localparam logic RegReuseEnable = 1'b0;

  function automatic class_t slot_mask(func_e f);
    class_t m;
    m = '0;
    unique case (f)
      FUNC_GET_LOCAL,  FUNC_FREE_LOCAL:  m = SLOT_LOCAL;
      FUNC_GET_REMOTE, FUNC_FREE_REMOTE: m = SLOT_REMOTE;
      FUNC_GET_IRQ,    FUNC_FREE_IRQ:    m = SLOT_IRQ;
      default:                           m = '0;
    endcase
    return m;
  endfunction

  // List preference for a get request, k = 0 is tried first.
  function automatic class_t search_class(func_e f, logic [1:0] k);
    class_t c;
    c = '0;
    unique case (f)
      FUNC_GET_LOCAL: begin
        if (k == 2'd0)      c = SLOT_LOCAL;
        else if (k == 2'd1) c = SLOT_LOCAL | SLOT_REMOTE;
        else                c = SLOT_LOCAL | SLOT_IRQ;
      end
      FUNC_GET_REMOTE: begin
        if (k == 2'd0)      c = SLOT_REMOTE;
        else if (k == 2'd1) c = SLOT_REMOTE | SLOT_IRQ;
        else                c = SLOT_LOCAL | SLOT_REMOTE;
      end
      FUNC_GET_IRQ: begin
        if (k == 2'd0)      c = SLOT_IRQ;
        else if (k == 2'd1) c = SLOT_REMOTE | SLOT_IRQ;
        else                c = SLOT_LOCAL | SLOT_IRQ;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/three_slot_descriptor_packer.sv
// Descriptor pool allocator for local, remote and interrupt slots. Each request word
// (get or free of one slot kind) is captured in an input register, resolved in one pass
// of logic against the descriptor state, and its result is held in an output register.
// A new word can be taken every cycle while the output is not stalled. The state updates
// at the same edge that loads the result, so back-to-back requests always see the effect
// of the previous one. All descriptor state (classes, list links, seven list heads) lives
// in flip-flops; classes and heads clear at reset, links need no reset. With reuse_enable
// set, a get takes the head of the first non-empty list in its preference order, else it
// opens the lowest unused descriptor (priority encoder). reuse_enable sits at address 0.
module three_slot_descriptor_packer #(
  parameter int DESCRIPTORS = tsdp_pkg::DescriptorsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [3:0]  desc_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  granted_index_o,
  output logic [1:0]  status_o,
  output logic        opened_new_o,
  output logic        closed_o
);
  import tsdp_pkg::*;

  localparam int IW = $clog2(DESCRIPTORS + 1);
  localparam int AW = (DESCRIPTORS > 1) ? $clog2(DESCRIPTORS) : 1;

  typedef logic [IW-1:0] link_t;
  typedef logic [AW-1:0] addr_t;

  localparam link_t Nil = IW'(DESCRIPTORS);

  // configuration
  logic reuse_q;

  // input and output registers
  logic        s1_valid_q;
  logic [2:0]  func_q;
  logic [3:0]  desc_q;
  logic        out_valid_q;
  logic [3:0]  granted_q, granted_d;
  status_e     status_q, status_d;
  logic        opened_q, opened_d;
  logic        closed_q, closed_d;
  logic        advance;

  // descriptor state
  class_t class_q [DESCRIPTORS];
  class_t class_d [DESCRIPTORS];
  link_t  next_q  [DESCRIPTORS];
  link_t  next_d  [DESCRIPTORS];
  link_t  prev_q  [DESCRIPTORS];
  link_t  prev_d  [DESCRIPTORS];
  link_t  head_q  [ListCount];
  link_t  head_d  [ListCount];

  // decoded actions
  logic   do_unlink, do_push, do_close;
  addr_t  u_a, p_a;
  class_t p_class;

  logic   free_found;
  addr_t  free_a;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegReuseEnable) ? {31'b0, reuse_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reuse_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegReuseEnable) begin
      reuse_q <= pwdata[0];
    end
  end

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      func_q <= func_i;
      desc_q <= desc_index_i;
    end
    if (advance) begin
      granted_q <= granted_d;
      status_q  <= status_d;
      opened_q  <= opened_d;
      closed_q  <= closed_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_index_o = granted_q;
  assign status_o        = status_q;
  assign opened_new_o    = opened_q;
  assign closed_o        = closed_q;

  // lowest unused descriptor
  always_comb begin
    free_found = 1'b0;
    free_a     = '0;
    for (int i = DESCRIPTORS - 1; i >= 0; i--) begin
      if (class_q[i] == CLASS_UNUSED) begin
        free_found = 1'b1;
        free_a     = AW'(i);
      end
    end
  end

  // request decode
  always_comb begin
    func_e  f;
    class_t m;
    logic   hit;
    class_t r_class;
    link_t  r_head;
    class_t c;
    addr_t  f_a;
    class_t f_class;
    logic   in_range;

    f        = func_e'(func_q);
    m        = slot_mask(f);
    hit      = 1'b0;
    r_class  = '0;
    r_head   = '0;
    f_a      = AW'(desc_q);
    f_class  = class_q[f_a];
    in_range = 32'(desc_q) < 32'(DESCRIPTORS);

    for (int k = 0; k < 3; k++) begin
      c = search_class(f, 2'(k));
      if (!hit && head_q[c] < Nil) begin
        hit     = 1'b1;
        r_class = c;
        r_head  = head_q[c];
      end
    end

    do_unlink = 1'b0;
    do_push   = 1'b0;
    do_close  = 1'b0;
    u_a       = '0;
    p_a       = '0;
    p_class   = '0;
    granted_d = '0;
    status_d  = ST_OK;
    opened_d  = 1'b0;
    closed_d  = 1'b0;

    unique case (f)
      FUNC_GET_LOCAL, FUNC_GET_REMOTE, FUNC_GET_IRQ: begin
        if (reuse_q && hit) begin
          do_unlink = 1'b1;
          u_a       = AW'(r_head);
          do_push   = 1'b1;
          p_a       = AW'(r_head);
          p_class   = r_class & ~m;
          granted_d = 4'(r_head);
        end else if (free_found) begin
          do_push   = 1'b1;
          p_a       = free_a;
          p_class   = CLASS_UNUSED & ~m;
          granted_d = 4'(free_a);
          opened_d  = 1'b1;
        end else begin
          status_d = ST_EXHAUSTED;
        end
      end
      FUNC_FREE_LOCAL, FUNC_FREE_REMOTE, FUNC_FREE_IRQ: begin
        if (!in_range || f_class == CLASS_UNUSED) begin
          status_d = ST_NOT_IN_USE;
        end else if ((f_class & m) != '0) begin
          status_d = ST_NOT_HELD;
        end else begin
          do_unlink = 1'b1;
          u_a       = f_a;
          if ((f_class | m) == CLASS_UNUSED) begin
            do_close = 1'b1;
            closed_d = 1'b1;
          end else begin
            do_push = 1'b1;
            p_a     = f_a;
            p_class = f_class | m;
          end
        end
      end
      default: ;
    endcase
  end

  // list surgery: unlink from the old list, push on the front of the new one
  always_comb begin
    class_t u_c;
    link_t  u_p;
    link_t  u_n;
    link_t  n2;

    class_d = class_q;
    next_d  = next_q;
    prev_d  = prev_q;
    head_d  = head_q;
    u_c     = class_q[u_a];
    u_p     = prev_q[u_a];
    u_n     = next_q[u_a];
    n2      = head_q[p_class];

    if (do_unlink) begin
      if (u_p < Nil) begin
        next_d[AW'(u_p)] = u_n;
      end else begin
        head_d[u_c] = u_n;
      end
      if (u_n < Nil) begin
        prev_d[AW'(u_n)] = u_p;
      end
    end
    if (do_push) begin
      next_d[p_a] = n2;
      prev_d[p_a] = Nil;
      if (n2 < Nil) begin
        prev_d[AW'(n2)] = IW'(p_a);
      end
      head_d[p_class] = IW'(p_a);
      class_d[p_a]    = p_class;
    end
    if (do_close) begin
      class_d[u_a] = CLASS_UNUSED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DESCRIPTORS; i++) begin
        class_q[i] <= CLASS_UNUSED;
      end
      for (int i = 0; i < ListCount; i++) begin
        head_q[i] <= Nil;
      end
    end else if (advance) begin
      class_q <= class_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      next_q <= next_d;
      prev_q <= prev_d;
    end
  end

  // a non-empty list head always points at a descriptor of that class
  for (genvar c = 0; c < ListCount; c++) begin : g_head_chk
    a_head_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (head_q[c] < Nil) |-> (class_q[AW'(head_q[c])] == class_t'(c)))
      else $error("list head points at descriptor of another class");
  end

  a_close_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && do_close) |=> (class_q[$past(u_a)] == CLASS_UNUSED))
    else $error("closed descriptor not marked unused");

  a_open_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && opened_q) |-> (status_q == ST_OK && !closed_q))
    else $error("open reported with error status or close");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

endmodule
